// ===== sv/mhpf_pkg.sv =====
// Shared types, codes and helpers of the 802.15.4 MAC header parser and filter.
package mhpf_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_SECURITY  = 2'd2,
        STATUS_ACK_ADDR  = 2'd3
    } status_t;

    // Address class against this node's own addresses
    typedef enum logic [1:0] {
        CLASS_HOST       = 2'd0,
        CLASS_BROADCAST  = 2'd1,
        CLASS_OTHERHOST  = 2'd2
    } pkt_class_t;

    // Delivery path by frame type
    typedef enum logic [1:0] {
        DELIV_DATA       = 2'd0,
        DELIV_COMMAND    = 2'd1,
        DELIV_DROP       = 2'd2
    } delivery_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_OWN_PAN_ID     = 2'd0;
    localparam logic [1:0] CFG_OWN_SHORT_ADDR = 2'd1;
    localparam logic [1:0] CFG_OWN_LONG_ADDR  = 2'd2;

    // Address modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SHORT = 2'd2;
    localparam logic [1:0] MODE_LONG  = 2'd3;

    // Frame types
    localparam logic [2:0] FTYPE_DATA = 3'd1;
    localparam logic [2:0] FTYPE_ACK  = 3'd2;
    localparam logic [2:0] FTYPE_CMD  = 3'd3;

    // Frame control bit positions
    localparam int FC_SEC_BIT    = 3;
    localparam int FC_ACKREQ_BIT = 5;
    localparam int FC_INTRA_BIT  = 6;

    // Byte positions inside the header
    localparam logic [4:0] POS_FC_LO   = 5'd0;
    localparam logic [4:0] POS_FC_HI   = 5'd1;
    localparam logic [4:0] POS_SEQ     = 5'd2;
    localparam logic [4:0] POS_ADDRS   = 5'd3;
    localparam logic [4:0] PAN_BYTES   = 5'd2;

    localparam logic [15:0] PAN_BROADCAST   = 16'hffff;
    localparam logic [63:0] SHORT_BROADCAST = 64'h0000_0000_0000_ffff;

    localparam int TDATA_W = 184;

    // Decoded header fields handed to the filter
    typedef struct packed {
        logic [2:0]  frame_type;
        logic [1:0]  dst_mode;
        logic [1:0]  src_mode;
        logic [15:0] dst_pan;
        logic [63:0] dst_addr;
    } hdr_t;

    // Classification result
    typedef struct packed {
        pkt_class_t pkt_class;
        delivery_t  delivery;
    } filt_t;

    // Address length in bytes for an address mode (reserved mode reads as long)
    function automatic logic [4:0] addr_bytes(input logic [1:0] mode);
        logic [4:0] n;
        begin
            case (mode)
                MODE_NONE:  n = 5'd0;
                MODE_SHORT: n = 5'd2;
                default:    n = 5'd8;
            endcase
            return n;
        end
    endfunction

endpackage

// ===== sv/mhpf_filter.sv =====
// Address class and delivery path of a completed header.
module mhpf_filter (
    input  mhpf_pkg::hdr_t  hdr,
    input  logic [15:0]     own_pan_id,
    input  logic [15:0]     own_short_addr,
    input  logic [63:0]     own_long_addr,
    output mhpf_pkg::filt_t filt
);
    import mhpf_pkg::*;

    logic pan_ok;

    assign pan_ok = (hdr.dst_pan == own_pan_id) || (hdr.dst_pan == PAN_BROADCAST);

    // Class against own addresses
    always_comb begin
        if (hdr.dst_mode == MODE_NONE) begin
            filt.pkt_class = (hdr.src_mode != MODE_NONE) ? CLASS_OTHERHOST : CLASS_HOST;
        end else if (!pan_ok) begin
            filt.pkt_class = CLASS_OTHERHOST;
        end else if (hdr.dst_mode == MODE_SHORT) begin
            if (hdr.dst_addr == SHORT_BROADCAST) begin
                filt.pkt_class = CLASS_BROADCAST;
            end else if (hdr.dst_addr == {48'd0, own_short_addr}) begin
                filt.pkt_class = CLASS_HOST;
            end else begin
                filt.pkt_class = CLASS_OTHERHOST;
            end
        end else if (hdr.dst_mode == MODE_LONG && hdr.dst_addr == own_long_addr) begin
            filt.pkt_class = CLASS_HOST;
        end else begin
            filt.pkt_class = CLASS_OTHERHOST;
        end
    end

    // Delivery by frame type
    always_comb begin
        if (hdr.frame_type == FTYPE_DATA) begin
            filt.delivery = DELIV_DATA;
        end else if (hdr.frame_type <= FTYPE_CMD) begin
            filt.delivery = DELIV_COMMAND;
        end else begin
            filt.delivery = DELIV_DROP;
        end
    end

endmodule

// ===== sv/mac_header_parse_and_filter_core.sv =====
// Top level of the 802.15.4 MAC header parser and receive filter.
// Frame bytes enter on the slave stream one per transaction, starting at the
// frame control word, with s_tlast on the final byte. The parser accepts a byte
// on every cycle while the single output register, which sets the rate, is
// empty or being drained. One result transaction per frame is loaded into it
// with the byte that completes the header (or that ends the frame early, or
// that reveals the security bit or an acknowledgment with addresses) and
// leaves on the master stream. Payload bytes after the header are swallowed
// until s_tlast. Own PAN id, short and long addresses are written through the
// cfg_* port; the user must do so only while no frame is in flight, as the
// block itself does not enforce it.
module mac_header_parse_and_filter_core (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    // receive byte stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tlast,   // last_byte
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] frame_type, [3] ack_request, [11:4] seq_num, [13:12] dst_mode,
    // [15:14] src_mode, [31:16] dst_pan, [47:32] src_pan, [111:48] dst_addr,
    // [175:112] src_addr, [177:176] packet_class, [179:178] delivery, rest zero
    output logic [mhpf_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]   m_tuser    // [1:0] status
);
    import mhpf_pkg::*;

    // Configuration registers
    logic [15:0] own_pan_reg;
    logic [15:0] own_short_reg;
    logic [63:0] own_long_reg;

    // Parser state
    logic [4:0]  byte_pos_reg,  byte_pos_next;
    logic [15:0] fc_reg,        fc_next;
    logic [7:0]  seq_reg,       seq_next;
    logic [15:0] dst_pan_reg,   dst_pan_next;
    logic [15:0] src_pan_reg,   src_pan_next;
    logic [63:0] dst_addr_reg,  dst_addr_next;
    logic [63:0] src_addr_reg,  src_addr_next;
    logic        done_reg,      done_next;

    // Output register
    logic                 m_valid_reg;
    logic [TDATA_W-1:0]   m_data_reg;
    logic [1:0]           m_user_reg;

    logic        s_accept;
    logic [1:0]  dm, sm;
    logic        intra;
    logic [4:0]  q, q_inc;
    logic [4:0]  daddr_len, saddr_len, src_off, saddr_off, hdr_len, rel;
    logic        emit;
    status_t     status;
    logic [15:0] span;
    hdr_t        hdr;
    filt_t       filt;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign dm    = fc_reg[11:10];
    assign sm    = fc_reg[15:14];
    assign intra = fc_reg[FC_INTRA_BIT];
    assign q     = byte_pos_reg;
    assign q_inc = q + 5'd1;

    // Field layout of the header from the frame control word
    always_comb begin
        daddr_len = addr_bytes(dm);
        saddr_len = addr_bytes(sm);
        src_off   = (dm != MODE_NONE) ? (POS_ADDRS + PAN_BYTES + daddr_len) : POS_ADDRS;
        saddr_off = (sm != MODE_NONE && !intra) ? (src_off + PAN_BYTES) : src_off;
        hdr_len   = (sm != MODE_NONE) ? (saddr_off + saddr_len) : src_off;
    end

    // Place the byte into the header fields and decide on a result
    always_comb begin
        byte_pos_next = byte_pos_reg;
        fc_next       = fc_reg;
        seq_next      = seq_reg;
        dst_pan_next  = dst_pan_reg;
        src_pan_next  = src_pan_reg;
        dst_addr_next = dst_addr_reg;
        src_addr_next = src_addr_reg;
        done_next     = done_reg;
        emit          = 1'b0;
        status        = STATUS_OK;
        rel           = 5'd0;

        if (!done_reg) begin
            case (q)
                POS_FC_LO: begin
                    fc_next       = {8'd0, s_tdata};
                    seq_next      = 8'd0;
                    dst_pan_next  = 16'd0;
                    src_pan_next  = 16'd0;
                    dst_addr_next = 64'd0;
                    src_addr_next = 64'd0;
                end
                POS_FC_HI: begin
                    fc_next[15:8] = s_tdata;
                end
                POS_SEQ: begin
                    seq_next = s_tdata;
                end
                default: begin
                    if (dm != MODE_NONE && q < POS_ADDRS + PAN_BYTES) begin
                        rel = q - POS_ADDRS;
                        dst_pan_next[{rel[0], 3'b000} +: 8] = s_tdata;
                    end else if (dm != MODE_NONE && q < src_off) begin
                        rel = q - (POS_ADDRS + PAN_BYTES);
                        dst_addr_next[{rel[2:0], 3'b000} +: 8] = s_tdata;
                    end else if (sm != MODE_NONE && q >= src_off && q < saddr_off) begin
                        rel = q - src_off;
                        src_pan_next[{rel[0], 3'b000} +: 8] = s_tdata;
                    end else if (sm != MODE_NONE && q >= saddr_off && q < hdr_len) begin
                        rel = q - saddr_off;
                        src_addr_next[{rel[2:0], 3'b000} +: 8] = s_tdata;
                    end
                end
            endcase

            byte_pos_next = q_inc;
            if (q_inc >= POS_ADDRS) begin
                if (q_inc == POS_ADDRS && fc_reg[FC_SEC_BIT]) begin
                    status    = STATUS_SECURITY;
                    emit      = 1'b1;
                    done_next = 1'b1;
                end else if (q_inc == POS_ADDRS && fc_reg[2:0] == FTYPE_ACK &&
                             (dm != MODE_NONE || sm != MODE_NONE)) begin
                    status    = STATUS_ACK_ADDR;
                    emit      = 1'b1;
                    done_next = 1'b1;
                end else if (q_inc >= hdr_len) begin
                    status    = STATUS_OK;
                    emit      = 1'b1;
                    done_next = 1'b1;
                end
            end
            if (!done_next && s_tlast) begin
                status = STATUS_SHORT;
                emit   = 1'b1;
            end
        end

        // Rearm on the final byte
        if (s_tlast) begin
            byte_pos_next = 5'd0;
            done_next     = 1'b0;
        end
    end

    // Source PAN id: copy of the destination one under compression (zero when there is no destination address)
    always_comb begin
        if (intra) begin
            span = (dm != MODE_NONE) ? dst_pan_next : 16'd0;
        end else begin
            span = src_pan_next;
        end
    end

    assign hdr.frame_type = fc_next[2:0];
    assign hdr.dst_mode   = fc_next[11:10];
    assign hdr.src_mode   = fc_next[15:14];
    assign hdr.dst_pan    = dst_pan_next;
    assign hdr.dst_addr   = dst_addr_next;

    mhpf_filter u_filter (
        .hdr            (hdr),
        .own_pan_id     (own_pan_reg),
        .own_short_addr (own_short_reg),
        .own_long_addr  (own_long_reg),
        .filt           (filt)
    );

    // Hold configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_pan_reg   <= 16'hffff;
            own_short_reg <= 16'hffff;
            own_long_reg  <= 64'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OWN_PAN_ID:     own_pan_reg   <= cfg_wdata[15:0];
                CFG_OWN_SHORT_ADDR: own_short_reg <= cfg_wdata[15:0];
                CFG_OWN_LONG_ADDR:  own_long_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance parser state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= 5'd0;
            fc_reg       <= 16'd0;
            seq_reg      <= 8'd0;
            dst_pan_reg  <= 16'd0;
            src_pan_reg  <= 16'd0;
            dst_addr_reg <= 64'd0;
            src_addr_reg <= 64'd0;
            done_reg     <= 1'b0;
        end else if (s_accept) begin
            byte_pos_reg <= byte_pos_next;
            fc_reg       <= fc_next;
            seq_reg      <= seq_next;
            dst_pan_reg  <= dst_pan_next;
            src_pan_reg  <= src_pan_next;
            dst_addr_reg <= dst_addr_next;
            src_addr_reg <= src_addr_next;
            done_reg     <= done_next;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            m_user_reg <= status;
            if (status == STATUS_OK) begin
                m_data_reg <= {4'd0, filt.delivery, filt.pkt_class,
                               src_addr_next, dst_addr_next, span, dst_pan_next,
                               fc_next[15:14], fc_next[11:10], seq_next,
                               fc_next[FC_ACKREQ_BIT], fc_next[2:0]};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
